/* hw/rtl/point_in_polygon_crossing_macros.svh */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_macros.svh
// Assertion macros for the point-in-polygon block; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is asserted
`define PIPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds while reset is asserted
`define PIPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PIPC_ASSERT(lbl, clk, rstn, prop, msg)
`define PIPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/pipc_pkg.sv */
// ----------------------------------------------------------------------------
// pipc_pkg
// Widths and the exact edge-crossing test for the point-in-polygon block.
// ----------------------------------------------------------------------------
package pipc_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  // one coordinate difference and one cross product
  localparam int unsigned DIFF_W      = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  // slave tdata: four coordinates, padded to whole bytes
  localparam int unsigned S_TDATA_W   = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W   = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // Edge from a to b against point p. Toggles when exactly one endpoint
  // lies strictly above p.y and p.x is on or left of the crossing x:
  //   (px - ax) * dy  <=  (bx - ax) * (py - ay)   for dy > 0, reversed else.
  function automatic logic edge_toggles(coord_t px, coord_t py, coord_t ax,
                                        coord_t ay, coord_t bx, coord_t by);
    diff_t dx_p;
    diff_t dx_e;
    diff_t dy_p;
    diff_t dy_e;
    prod_t lhs;
    prod_t rhs;
    logic  hit;
    dx_p = diff_t'(px) - diff_t'(ax);
    dx_e = diff_t'(bx) - diff_t'(ax);
    dy_p = diff_t'(py) - diff_t'(ay);
    dy_e = diff_t'(by) - diff_t'(ay);
    lhs  = prod_t'(dx_p) * prod_t'(dy_e);
    rhs  = prod_t'(dx_e) * prod_t'(dy_p);
    if ((ay > py) == (by > py)) begin
      hit = 1'b0;
    end else if (dy_e[DIFF_W-1]) begin
      hit = (lhs >= rhs);
    end else begin
      hit = (lhs <= rhs);
    end
    return hit;
  endfunction

endpackage

/* hw/rtl/point_in_polygon_crossing.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// Even-odd point-in-polygon test over a stream of polygon vertices.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                         | tlast
//  ---------+-----+--------------------------------------------+------------
//  s_axis   | in  | vertex_x, vertex_y, point_x, point_y       | last_vertex
//  m_axis   | out | inside_res                                 | -
//
//  One vertex beat per cycle while no result waits on a last vertex. A vertex
//  is held in the input register, where the edge tests (four 17x17 products at
//  most, on the last vertex) run against the running state, and the result
//  lands in the output register.
//  Reset clears the valid flags, the parity and re-arms first-vertex capture.
//  A waiting result stalls the input stage only when it holds a last vertex.
//
`include "point_in_polygon_crossing_macros.svh"

module point_in_polygon_crossing
  import pipc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // vertex_x, vertex_y, point_x, point_y (COORD_WIDTH each, from bit 0)
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // inside_res (bit 0), zero padded
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i
);

  localparam int unsigned CW = COORD_WIDTH;

  // input register
  logic   in_valid_q, in_valid_d;
  coord_t vx_q, vy_q, px_in_q, py_in_q;
  logic   last_q;
  // running polygon state
  coord_t first_x_q, first_y_q, prev_x_q, prev_y_q, held_x_q, held_y_q;
  logic   parity_q, parity_d;
  logic   awaiting_q;
  // output register
  logic   out_valid_q, out_valid_d;
  logic   inside_q;

  logic   s_beat, advance, out_free, emit;
  logic   tog_prev, tog_close, parity_new;

  // handshake
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!last_q || out_free);
  assign emit            = advance && last_q;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      vx_q    <= coord_t'(s_axis_tdata_i[CW-1:0]);
      vy_q    <= coord_t'(s_axis_tdata_i[2*CW-1:CW]);
      px_in_q <= coord_t'(s_axis_tdata_i[3*CW-1:2*CW]);
      py_in_q <= coord_t'(s_axis_tdata_i[4*CW-1:3*CW]);
      last_q  <= s_axis_tlast_i;
    end
  end

  // edge tests: current to previous, and closing edge on the last vertex
  assign tog_prev  = edge_toggles(held_x_q, held_y_q, vx_q, vy_q, prev_x_q, prev_y_q);
  assign tog_close = last_q &&
                     edge_toggles(held_x_q, held_y_q, first_x_q, first_y_q, vx_q, vy_q);
  assign parity_new = awaiting_q ? 1'b0 : (parity_q ^ tog_prev ^ tog_close);
  assign parity_d   = last_q ? 1'b0 : parity_new;

  // output valid next state
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      parity_q    <= 1'b0;
      awaiting_q  <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        parity_q   <= parity_d;
        awaiting_q <= last_q;
      end
    end
  end

  // geometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
    end else if (advance) begin
      prev_x_q <= vx_q;
      prev_y_q <= vy_q;
      if (awaiting_q) begin
        first_x_q <= vx_q;
        first_y_q <= vy_q;
        held_x_q  <= px_in_q;
        held_y_q  <= py_in_q;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      inside_q <= parity_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-1){1'b0}}, inside_q};

  // checks
  `PIPC_ASSERT(a_last_emits, clk_i, rst_ni, emit |=> out_valid_q, "last vertex gave no result")
  `PIPC_ASSERT(a_last_rearms, clk_i, rst_ni, emit |=> (awaiting_q && !parity_q), "polygon state not re-armed")
  `PIPC_ASSERT(a_mid_vertex, clk_i, rst_ni, (advance && !last_q) |=> !awaiting_q, "first-vertex capture left armed")
  `PIPC_ASSERT(a_single_vertex, clk_i, rst_ni, (emit && awaiting_q) |=> (m_axis_tdata_o[0] == 1'b0), "one-vertex polygon reported inside")
  `PIPC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!out_valid_q && !in_valid_q), "valid set in reset")

endmodule
